@@ hw/rtl/srti_pkg.sv @@
// shared types and constants for the sorted relocation table insert unit
package srti_pkg;

    localparam int ACTION_W    = 2;
    localparam int WORD_W      = 16;
    localparam int INDEX_W     = 10;
    localparam int ADDR_W      = 21;
    localparam int POS_W       = 10;
    localparam int COUNT_W     = 11;
    localparam int TALLY_W     = 10;
    localparam int PARA_SHIFT  = 4;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 72;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 10'd1023;

    typedef struct packed {
        logic [5:0]          pad;
        logic [INDEX_W-1:0]  read_index;
        logic [WORD_W-1:0]   reloc_segment;
        logic [WORD_W-1:0]   reloc_offset;
    } request_t;

    typedef struct packed {
        logic [6:0]          pad;
        logic [TALLY_W-1:0]  shifted_count;
        logic [TALLY_W-1:0]  appended_count;
        logic [COUNT_W-1:0]  entry_count;
        logic                table_full;
        logic                duplicate_found;
        logic                was_appended;
        logic [POS_W-1:0]    insert_position;
        logic [ADDR_W-1:0]   linear_address;
    } result_t;

endpackage

@@ hw/rtl/sorted_relocation_table_insert_unit.sv @@
// sorted relocation table: linear-search insert, indexed read and clear
// One request at a time through a table memory with one write port and a
// registered read port. An insert at position p searches the stored entries
// in order from position 0, moves the entries from p up one place, top entry
// first, and writes the new entry at p. Each search step and each move step
// is one memory read and one compare or write. A read inside the stored
// entries passes ST_READ_RD and ST_READ_GET; a read past them, a clear, an
// unused action or a refused insert goes straight from ST_IDLE to ST_DONE. The
// result waits in an output register, so the next request is taken once the
// current one has finished, even while its result is still held. The table
// contents are not cleared; the entry count alone tells which entries are valid.
module sorted_relocation_table_insert_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // reloc_offset[15:0], reloc_segment[31:16], read_index[41:32]
    input  logic [srti_pkg::S_TDATA_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [srti_pkg::ACTION_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // linear_address[20:0], insert_position[30:21], was_appended[31],
    // duplicate_found[32], table_full[33], entry_count[44:34],
    // appended_count[54:45], shifted_count[64:55]
    output logic [srti_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > srti_pkg::INDEX_W) ? CW : srti_pkg::INDEX_W;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SRCH_RD  = 4'd1;
    localparam logic [3:0] ST_SRCH_CMP = 4'd2;
    localparam logic [3:0] ST_SHIFT_RD = 4'd3;
    localparam logic [3:0] ST_SHIFT_WR = 4'd4;
    localparam logic [3:0] ST_INS_WR   = 4'd5;
    localparam logic [3:0] ST_READ_RD  = 4'd6;
    localparam logic [3:0] ST_READ_GET = 4'd7;
    localparam logic [3:0] ST_DONE     = 4'd8;

    localparam logic [1:0] KIND_FIRST  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_SHIFT  = 2'd2;

    logic [srti_pkg::ADDR_W-1:0] table_mem [TABLE_DEPTH];

    logic [3:0]                   state_reg, state_next;
    logic [AW-1:0]                idx_reg, idx_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [srti_pkg::TALLY_W-1:0] app_tally_reg, app_tally_next;
    logic [srti_pkg::TALLY_W-1:0] shf_tally_reg, shf_tally_next;
    logic [srti_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [1:0]                   kind_reg, kind_next;
    logic                         app_reg, app_next;
    logic                         dup_reg, dup_next;
    logic                         full_reg, full_next;
    logic [srti_pkg::ADDR_W-1:0]  rd_data_reg;
    logic                         m_tvalid_reg, m_tvalid_next;
    srti_pkg::result_t            m_tdata_reg, m_tdata_next;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [srti_pkg::ADDR_W-1:0]  wr_data;

    srti_pkg::request_t           req;
    logic [srti_pkg::ADDR_W-1:0]  req_addr;
    logic                         out_free;

    assign req      = srti_pkg::request_t'(s_tdata);
    assign req_addr = (srti_pkg::ADDR_W'(req.reloc_segment) << srti_pkg::PARA_SHIFT)
                    + srti_pkg::ADDR_W'(req.reloc_offset);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[idx_reg];
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        app_tally_next = app_tally_reg;
        shf_tally_next = shf_tally_reg;
        addr_next      = addr_reg;
        kind_next      = kind_reg;
        app_next       = app_reg;
        dup_next       = dup_reg;
        full_next      = full_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        wr_en          = 1'b0;
        wr_addr        = pos_reg;
        wr_data        = addr_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    addr_next = '0;
                    pos_next  = '0;
                    app_next  = 1'b0;
                    dup_next  = 1'b0;
                    full_next = 1'b0;
                    state_next = ST_DONE;
                    unique case (s_tuser)
                        srti_pkg::ACT_INSERT: begin
                            addr_next = req_addr;
                            if (count_reg >= CW'(TABLE_DEPTH)) begin
                                full_next = 1'b1;
                            end else if (count_reg == '0) begin
                                kind_next  = KIND_FIRST;
                                state_next = ST_INS_WR;
                            end else begin
                                idx_next   = '0;
                                state_next = ST_SRCH_RD;
                            end
                        end
                        srti_pkg::ACT_READ: begin
                            if (CMPW'(req.read_index) < CMPW'(count_reg)) begin
                                idx_next   = AW'(req.read_index);
                                state_next = ST_READ_RD;
                            end
                        end
                        srti_pkg::ACT_CLEAR: begin
                            count_next     = '0;
                            app_tally_next = '0;
                            shf_tally_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                if (rd_data_reg < addr_reg) begin
                    if (CW'(idx_reg) + CW'(1) == count_reg) begin
                        pos_next   = idx_reg + AW'(1);
                        kind_next  = KIND_APPEND;
                        app_next   = 1'b1;
                        state_next = ST_INS_WR;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_SRCH_RD;
                    end
                end else if (rd_data_reg == addr_reg) begin
                    pos_next   = idx_reg;
                    dup_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    pos_next   = idx_reg;
                    idx_next   = AW'(count_reg - CW'(1));
                    kind_next  = KIND_SHIFT;
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                wr_data = rd_data_reg;
                if (idx_reg == pos_reg) begin
                    state_next = ST_INS_WR;
                end else begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_INS_WR: begin
                wr_en      = 1'b1;
                count_next = count_reg + CW'(1);
                if (kind_reg == KIND_APPEND && app_tally_reg != srti_pkg::TALLY_MAX) begin
                    app_tally_next = app_tally_reg + srti_pkg::TALLY_W'(1);
                end
                if (kind_reg == KIND_SHIFT && shf_tally_reg != srti_pkg::TALLY_MAX) begin
                    shf_tally_next = shf_tally_reg + srti_pkg::TALLY_W'(1);
                end
                state_next = ST_DONE;
            end
            ST_READ_RD: begin
                state_next = ST_READ_GET;
            end
            ST_READ_GET: begin
                addr_next  = rd_data_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next                = 1'b1;
                    m_tdata_next.pad             = '0;
                    m_tdata_next.linear_address  = addr_reg;
                    m_tdata_next.insert_position = srti_pkg::POS_W'(pos_reg);
                    m_tdata_next.was_appended    = app_reg;
                    m_tdata_next.duplicate_found = dup_reg;
                    m_tdata_next.table_full      = full_reg;
                    m_tdata_next.entry_count     = srti_pkg::COUNT_W'(count_reg);
                    m_tdata_next.appended_count  = app_tally_reg;
                    m_tdata_next.shifted_count   = shf_tally_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            app_tally_reg <= '0;
            shf_tally_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            app_tally_reg <= app_tally_next;
            shf_tally_reg <= shf_tally_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        pos_reg     <= pos_next;
        addr_reg    <= addr_next;
        kind_reg    <= kind_next;
        app_reg     <= app_next;
        dup_reg     <= dup_next;
        full_reg    <= full_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

@@ hw/rtl/srti_checker.sv @@
// port-level checks for the sorted relocation table insert unit
module srti_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [srti_pkg::M_TDATA_W-1:0] m_tdata
);

    srti_pkg::result_t res;

    assign res = srti_pkg::result_t'(m_tdata);

    // held result stays put until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    // outcome flags are exclusive
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0({res.was_appended, res.duplicate_found, res.table_full}))
        else $error("conflicting insert flags");

    // refused insert reports position zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.table_full |-> res.insert_position == '0)
        else $error("full table with nonzero position");

endmodule

bind sorted_relocation_table_insert_unit srti_checker u_srti_checker (.*);
